// ===== rtl/stws_pkg.sv =====
// Package for the sum-tree weighted sampler: sizes, request kinds and tree constants.
// No dependencies; used by the top level and its RAM instance sizing.
`default_nettype none
package stws_pkg;

	localparam int LEAVES      = 1024;
	localparam int WEIGHT_BITS = 32;
	localparam int IDX_W       = 10;
	localparam int FRAC_W      = 17;
	localparam int NODE_W      = 42;
	localparam int ADDR_W      = 11;
	localparam int RAM_DEPTH   = 2048;
	localparam int KIND_W      = 2;

	localparam logic [ADDR_W-1:0] LEAF_BASE = ADDR_W'(LEAVES - 1);
	localparam logic [ADDR_W-1:0] ROOT_NODE = '0;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RAM_DEPTH - 1);
	localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(65536);

	localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DRAW     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAW_REM = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd3;

	typedef logic [NODE_W-1:0] node_sum_t;
	typedef logic [ADDR_W-1:0] node_addr_t;

	function automatic node_addr_t parent_of(input node_addr_t n);
		node_addr_t m;
		m = n - 1'b1;
		return {1'b0, m[ADDR_W-1:1]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/stws_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none
module stws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/sum_tree_weighted_sampler_unit.sv =====
// Top level of the sum-tree weighted sampler: request sequencer, shared multiplier and tree walk.
// Depends on stws_pkg and on stws_ram, which holds the node sums in heap order.
//
//  channel   ports                                        handshake
//  request   kind, leaf_index, weight, fraction           start high while busy is low
//  result    chosen_index, tree_empty, total_weight       done high for one cycle, no stall
//
// A load or remove reads the leaf, then does one read-modify-write per tree level from the
// leaf up to the root through the single RAM read and write ports. A draw makes two passes
// through the shared 17 by 26 bit multiplier, one add, one clamp, then one RAM read per level
// of the descent; draw and remove then runs the update walk after the descent. Draws on an
// empty tree finish straight from idle; a leaf index can never be outside the tree, as its 10
// bits cover all 1024 leaves. After reset a clearing pass writes zero to all 2048 RAM words,
// which keeps busy high until it ends. The receiver cannot stall, so results never back up.
`default_nettype none
module sum_tree_weighted_sampler_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [stws_pkg::KIND_W-1:0]   kind,
	input  wire logic [stws_pkg::IDX_W-1:0]    leaf_index,
	input  wire logic [stws_pkg::WEIGHT_BITS-1:0] weight,
	input  wire logic [stws_pkg::FRAC_W-1:0]   fraction,
	output logic                               done,
	output logic [stws_pkg::IDX_W-1:0]         chosen_index,
	output logic                               tree_empty,
	output logic [stws_pkg::NODE_W-1:0]        total_weight
);
	import stws_pkg::*;

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_MUL_HI = 4'd2;
	localparam logic [3:0] ST_MUL_LO = 4'd3;
	localparam logic [3:0] ST_ADD    = 4'd4;
	localparam logic [3:0] ST_SAT    = 4'd5;
	localparam logic [3:0] ST_DESC   = 4'd6;
	localparam logic [3:0] ST_UP_RD  = 4'd7;
	localparam logic [3:0] ST_UP_LF  = 4'd8;
	localparam logic [3:0] ST_UP_WK  = 4'd9;

	localparam int HI_W = NODE_W - 16;
	localparam int PROD_W = FRAC_W + HI_W;

	// Sequencer and control state.
	logic [3:0]        state_q;
	node_addr_t        node_q;
	node_sum_t         total_q;
	logic [KIND_W-1:0] kind_q;

	// Working registers of the current request.
	logic [IDX_W-1:0]  idx_q;
	logic [FRAC_W-1:0] frac_q;
	node_sum_t         new_w_q;
	node_sum_t         delta_q;
	node_sum_t         target_q;
	logic [PROD_W-1:0] p_hi_q;
	logic [PROD_W-1:0] p_lo_q;

	// RAM ports.
	logic       ram_we;
	node_addr_t ram_waddr;
	node_sum_t  ram_wdata;
	node_addr_t ram_raddr;
	node_sum_t  ram_rdata;

	stws_ram #(
		.WIDTH(NODE_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The single multiplier is shared by both halves of the scaling product.
	logic [HI_W-1:0]   mul_b;
	logic [PROD_W-1:0] mul_p;

	always_comb begin
		if (state_q == ST_MUL_HI) begin
			mul_b = total_q[NODE_W-1:16];
		end else begin
			mul_b = HI_W'(total_q[15:0]);
		end
		mul_p = PROD_W'(frac_q) * PROD_W'(mul_b);
	end

	// One descent step: the RAM returns the left child of node_q.
	node_addr_t left_c;
	logic       go_left;
	node_addr_t next_n;
	node_sum_t  next_t;
	logic       at_leaf;
	node_sum_t  walk_sum;
	logic       idx_ok;
	logic [NODE_W:0] scaled;

	always_comb begin
		left_c   = {node_q[ADDR_W-2:0], 1'b1};
		go_left  = target_q < ram_rdata;
		next_n   = go_left ? left_c : left_c + 1'b1;
		next_t   = go_left ? target_q : target_q - ram_rdata;
		at_leaf  = next_n >= LEAF_BASE;
		walk_sum = ram_rdata + delta_q;
		idx_ok   = {1'b0, leaf_index} < ADDR_W'(LEAVES);
		scaled   = (NODE_W+1)'(p_hi_q) + (NODE_W+1)'(p_lo_q >> 16);
	end

	// RAM address and write selection follow the sequencer state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = '0;
		ram_raddr = node_q;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_SAT: begin
				ram_raddr = ADDR_W'(1);
			end
			ST_DESC: begin
				ram_raddr = {next_n[ADDR_W-2:0], 1'b1};
			end
			ST_UP_LF: begin
				ram_we    = 1'b1;
				ram_wdata = new_w_q;
				ram_raddr = parent_of(node_q);
			end
			ST_UP_WK: begin
				ram_we    = 1'b1;
				ram_wdata = walk_sum;
				ram_raddr = parent_of(node_q);
			end
			default: begin
				ram_raddr = node_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			node_q  <= '0;
			total_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					node_q <= node_q + 1'b1;
					if (node_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						kind_q <= kind;
						idx_q  <= leaf_index;
						frac_q <= (fraction > FRAC_ONE) ? FRAC_ONE : fraction;
						case (kind) inside
							KIND_DRAW, KIND_DRAW_REM: begin
								if (total_q == '0) begin
									done <= 1'b1;
									chosen_index <= '0;
									tree_empty   <= 1'b1;
									total_weight <= total_q;
								end else begin
									state_q <= ST_MUL_HI;
								end
							end
							default: begin
								if (idx_ok) begin
									node_q  <= LEAF_BASE + ADDR_W'(leaf_index);
									new_w_q <= (kind == KIND_LOAD) ? NODE_W'(weight) : '0;
									state_q <= ST_UP_RD;
								end else begin
									done <= 1'b1;
									chosen_index <= leaf_index;
									tree_empty   <= (total_q == '0);
									total_weight <= total_q;
								end
							end
						endcase
					end
				end
				ST_MUL_HI: begin
					p_hi_q  <= mul_p;
					state_q <= ST_MUL_LO;
				end
				ST_MUL_LO: begin
					p_lo_q  <= mul_p;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					target_q <= scaled[NODE_W-1:0];
					state_q  <= ST_SAT;
				end
				ST_SAT: begin
					if (target_q >= total_q) begin
						target_q <= total_q - 1'b1;
					end
					node_q  <= ROOT_NODE;
					state_q <= ST_DESC;
				end
				ST_DESC: begin
					node_q   <= next_n;
					target_q <= next_t;
					if (at_leaf) begin
						idx_q <= IDX_W'(next_n - LEAF_BASE);
						if (kind_q == KIND_DRAW_REM) begin
							new_w_q <= '0;
							state_q <= ST_UP_RD;
						end else begin
							done <= 1'b1;
							chosen_index <= IDX_W'(next_n - LEAF_BASE);
							tree_empty   <= (total_q == '0);
							total_weight <= total_q;
							state_q      <= ST_IDLE;
						end
					end
				end
				ST_UP_RD: begin
					state_q <= ST_UP_LF;
				end
				ST_UP_LF: begin
					delta_q <= new_w_q - ram_rdata;
					node_q  <= parent_of(node_q);
					state_q <= ST_UP_WK;
				end
				ST_UP_WK: begin
					node_q <= parent_of(node_q);
					if (node_q == ROOT_NODE) begin
						total_q      <= walk_sum;
						done         <= 1'b1;
						chosen_index <= idx_q;
						tree_empty   <= (walk_sum == '0);
						total_weight <= walk_sum;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire
